// ----- hdl/fppid_pkg.sv -----
// ----------------------------------------------------------------------------
// fppid_pkg
// Shared widths, constants, register codes and types of the fixed-point PID.
// ----------------------------------------------------------------------------
package fppid_pkg;

  // Q format of the gains
  localparam int COEF_FRAC_BITS = 12;

  // Field widths
  localparam int SMP_W  = 16;  // setpoint and measurement
  localparam int ERR_W  = 17;  // error, increment, last error
  localparam int DE_W   = 18;  // error difference
  localparam int SUM_W  = 25;  // integral sum
  localparam int GAIN_W = 24;
  localparam int OUT_W  = 16;
  localparam int ACC_W  = 51;  // sum of the three products

  // Configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd7;

  // Mode bits
  localparam int MODE_ERR_DIV10 = 0;
  localparam int MODE_INC_DIV10 = 1;
  localparam int MODE_GATE      = 2;

  // Integral gate: increment passes only while |error| is below this
  localparam logic signed [ERR_W-1:0] GATE_POS = 17'sd5;
  localparam logic signed [ERR_W-1:0] GATE_NEG = -17'sd5;

  // Divide by 10 for values below 2^16: (x * 52429) >> 19
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Queue between front and back
  localparam int                QPTR_W = 3;
  localparam int                QCNT_W = 4;
  localparam logic [QCNT_W-1:0] QDEPTH = 4'd8;

  // Result buffer in the back end
  localparam int                OPTR_W = 3;
  localparam int                OCNT_W = 4;
  localparam logic [OCNT_W-1:0] ODEPTH = 4'd8;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [15:0]              error_limit;
    logic [23:0]              integral_limit;
    logic signed [OUT_W-1:0]  out_min;
    logic signed [OUT_W-1:0]  out_max;
    logic [2:0]               mode;
  } cfg_t;

  // One classified transaction handed from front to back
  typedef struct packed {
    logic                    en;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] inc;
  } fq_t;

endpackage

// ----- hdl/fppid_front.sv -----
// ----------------------------------------------------------------------------
// fppid_front
// Accepts input transactions and forms the clamped error and the integral
// increment in three stages; credit counter keeps the queue from overflowing.
// ----------------------------------------------------------------------------
module fppid_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fppid_pkg::cfg_t                        cfg,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fppid_pkg::SMP_W-1:0]     in_setpoint,
  input  logic signed [fppid_pkg::SMP_W-1:0]     in_measured,
  input  logic                                   in_enable,
  input  logic                                   q_pop,
  output logic                                   q_push,
  output fppid_pkg::fq_t                         q_data
);
  import fppid_pkg::*;

  logic                    acc_in;
  logic [QCNT_W-1:0]       cnt_r;
  logic [QCNT_W-1:0]       cnt_nxt;

  // stage 1 signals
  logic signed [ERR_W-1:0] diff;
  logic signed [ERR_W-1:0] diff_neg;
  logic [15:0]             adiff;
  logic [31:0]             prod1;
  logic                    s1_v_r;
  logic                    s1_en_r;
  logic signed [ERR_W-1:0] s1_diff_r;
  logic [12:0]             s1_q_r;

  // stage 2 signals
  logic signed [ERR_W-1:0] q1_pos;
  logic signed [ERR_W-1:0] e_div;
  logic signed [ERR_W-1:0] e_raw;
  logic signed [ERR_W-1:0] lim_pos;
  logic signed [ERR_W-1:0] lim_neg;
  logic signed [ERR_W-1:0] e_cl;
  logic                    s2_v_r;
  logic                    s2_en_r;
  logic signed [ERR_W-1:0] s2_err_r;

  // stage 3 signals
  logic signed [ERR_W-1:0] err_neg;
  logic [15:0]             aerr;
  logic [31:0]             prod2;
  logic signed [ERR_W-1:0] q2_pos;
  logic signed [ERR_W-1:0] inc_div;
  logic                    gate_hit;
  logic signed [ERR_W-1:0] inc;
  logic                    s3_v_r;
  fq_t                     s3_r;

  // Credit: transactions accepted and not yet popped from the queue
  assign in_stall = (cnt_r == QDEPTH);
  assign acc_in   = in_valid & ~in_stall;
  assign cnt_nxt  = cnt_r + {{(QCNT_W-1){1'b0}}, acc_in} - {{(QCNT_W-1){1'b0}}, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Stage 1: raw error and its magnitude divided by 10
  assign diff     = $signed({in_setpoint[SMP_W-1], in_setpoint})
                  - $signed({in_measured[SMP_W-1], in_measured});
  assign diff_neg = -diff;
  assign adiff    = diff[ERR_W-1] ? diff_neg[15:0] : diff[15:0];
  assign prod1    = {16'b0, adiff} * {16'b0, DIV10_MUL};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_en_r   <= in_enable;
      s1_diff_r <= diff;
      s1_q_r    <= prod1[31:DIV10_SHIFT];
    end
  end

  // Stage 2: select the scaled error and clamp to the error limit
  assign q1_pos  = $signed({4'b0, s1_q_r});
  assign e_div   = s1_diff_r[ERR_W-1] ? -q1_pos : q1_pos;
  assign e_raw   = cfg.mode[MODE_ERR_DIV10] ? e_div : s1_diff_r;
  assign lim_pos = $signed({1'b0, cfg.error_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (e_raw < lim_neg) begin
      e_cl = lim_neg;
    end else if (e_raw > lim_pos) begin
      e_cl = lim_pos;
    end else begin
      e_cl = e_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_en_r  <= s1_en_r;
      s2_err_r <= e_cl;
    end
  end

  // Stage 3: integral increment, scaled and gated
  assign err_neg  = -s2_err_r;
  assign aerr     = s2_err_r[ERR_W-1] ? err_neg[15:0] : s2_err_r[15:0];
  assign prod2    = {16'b0, aerr} * {16'b0, DIV10_MUL};
  assign q2_pos   = $signed({4'b0, prod2[31:DIV10_SHIFT]});
  assign inc_div  = s2_err_r[ERR_W-1] ? -q2_pos : q2_pos;
  assign gate_hit = (s2_err_r >= GATE_POS) || (s2_err_r <= GATE_NEG);

  always_comb begin
    if (cfg.mode[MODE_GATE] && gate_hit) begin
      inc = '0;
    end else if (cfg.mode[MODE_INC_DIV10]) begin
      inc = inc_div;
    end else begin
      inc = s2_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      s3_r.en  <= s2_en_r;
      s3_r.err <= s2_err_r;
      s3_r.inc <= inc;
    end
  end

  assign q_push = s3_v_r;
  assign q_data = s3_r;

endmodule

// ----- hdl/fppid_fifo.sv -----
// ----------------------------------------------------------------------------
// fppid_fifo
// Short queue of classified transactions between the front and back ends.
// ----------------------------------------------------------------------------
module fppid_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fppid_pkg::fq_t push_data,
  input  logic           pop,
  output logic           empty,
  output fppid_pkg::fq_t head
);
  import fppid_pkg::*;

  fq_t               mem_r [int'(QDEPTH)];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + {{(QCNT_W-1){1'b0}}, push} - {{(QCNT_W-1){1'b0}}, pop};
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/fppid_back.sv -----
// ----------------------------------------------------------------------------
// fppid_back
// Updates the integral and last error, forms the weighted sum of the three
// terms, scales and clamps it, and buffers results for the output channel.
// ----------------------------------------------------------------------------
module fppid_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fppid_pkg::cfg_t                      cfg,
  input  logic                                 q_empty,
  input  fppid_pkg::fq_t                       q_head,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fppid_pkg::OUT_W-1:0]   out_control_out
);
  import fppid_pkg::*;

  // credit for the result buffer
  logic [OCNT_W-1:0]       bcnt_r;
  logic                    out_take;

  // running state
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [ERR_W-1:0] last_r;
  logic signed [ERR_W-1:0] last_nxt;

  // stage 1
  logic signed [SUM_W:0]   sum_add;
  logic signed [SUM_W:0]   ilim_pos;
  logic signed [SUM_W:0]   ilim_neg;
  logic signed [SUM_W-1:0] sum_cl;
  logic signed [DE_W-1:0]  de;
  logic                    b1_v_r;
  logic                    b1_en_r;
  logic signed [ERR_W-1:0] b1_err_r;
  logic signed [SUM_W-1:0] b1_sum_r;
  logic signed [DE_W-1:0]  b1_de_r;

  // stage 2
  logic signed [40:0]      pp;
  logic signed [48:0]      pi;
  logic signed [41:0]      pd;
  logic                    b2_v_r;
  logic                    b2_en_r;
  logic signed [40:0]      b2_pp_r;
  logic signed [48:0]      b2_pi_r;
  logic signed [41:0]      b2_pd_r;

  // stage 3
  logic [ACC_W-1:0]        acc;
  logic                    b3_v_r;
  logic                    b3_en_r;
  logic [ACC_W-1:0]        b3_acc_r;

  // final scale and clamp
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] omin_ext;
  logic signed [ACC_W-1:0] omax_ext;
  logic signed [OUT_W-1:0] res_cl;
  logic signed [OUT_W-1:0] res;

  // result buffer
  logic signed [OUT_W-1:0] obuf_r [int'(ODEPTH)];
  logic [OPTR_W-1:0]       owr_r;
  logic [OPTR_W-1:0]       ord_r;
  logic [OCNT_W-1:0]       ocnt_r;

  // Pop from the queue while the result buffer still has a free slot
  assign q_pop    = ~q_empty && (bcnt_r != ODEPTH);
  assign out_take = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
    end else begin
      bcnt_r <= bcnt_r + {{(OCNT_W-1){1'b0}}, q_pop} - {{(OCNT_W-1){1'b0}}, out_take};
    end
  end

  // Stage 1: saturate the integral and take the error difference
  assign sum_add  = $signed({sum_r[SUM_W-1], sum_r})
                  + $signed({{(SUM_W+1-ERR_W){q_head.inc[ERR_W-1]}}, q_head.inc});
  assign ilim_pos = $signed({2'b0, cfg.integral_limit});
  assign ilim_neg = -ilim_pos;

  always_comb begin
    if (sum_add < ilim_neg) begin
      sum_cl = ilim_neg[SUM_W-1:0];
    end else if (sum_add > ilim_pos) begin
      sum_cl = ilim_pos[SUM_W-1:0];
    end else begin
      sum_cl = sum_add[SUM_W-1:0];
    end
  end

  assign de = $signed({q_head.err[ERR_W-1], q_head.err}) - $signed({last_r[ERR_W-1], last_r});

  // Hold state unless a transaction is popped; disabled clears history
  always_comb begin
    sum_nxt  = sum_r;
    last_nxt = last_r;
    if (q_pop) begin
      if (q_head.en) begin
        sum_nxt  = sum_cl;
        last_nxt = q_head.err;
      end else begin
        sum_nxt  = '0;
        last_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
      b1_v_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      last_r <= last_nxt;
      b1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_en_r  <= q_head.en;
      b1_err_r <= q_head.err;
      b1_sum_r <= sum_cl;
      b1_de_r  <= de;
    end
  end

  // Stage 2: the three gain products, operands sign-extended to product width
  assign pp = $signed({{(41-GAIN_W){cfg.gain_p[GAIN_W-1]}}, cfg.gain_p})
            * $signed({{(41-ERR_W){b1_err_r[ERR_W-1]}}, b1_err_r});
  assign pi = $signed({{(49-GAIN_W){cfg.gain_i[GAIN_W-1]}}, cfg.gain_i})
            * $signed({{(49-SUM_W){b1_sum_r[SUM_W-1]}}, b1_sum_r});
  assign pd = $signed({{(42-GAIN_W){cfg.gain_d[GAIN_W-1]}}, cfg.gain_d})
            * $signed({{(42-DE_W){b1_de_r[DE_W-1]}}, b1_de_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_v_r) begin
      b2_en_r <= b1_en_r;
      b2_pp_r <= pp;
      b2_pi_r <= pi;
      b2_pd_r <= pd;
    end
  end

  // Stage 3: add the terms
  assign acc = {{(ACC_W-41){b2_pp_r[40]}}, b2_pp_r}
             + {{(ACC_W-49){b2_pi_r[48]}}, b2_pi_r}
             + {{(ACC_W-42){b2_pd_r[41]}}, b2_pd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_v_r) begin
      b3_en_r  <= b2_en_r;
      b3_acc_r <= acc;
    end
  end

  // Floor shift to integer, then clamp to the output bounds
  assign shifted  = $signed(b3_acc_r) >>> COEF_FRAC_BITS;
  assign omin_ext = $signed({{(ACC_W-OUT_W){cfg.out_min[OUT_W-1]}}, cfg.out_min});
  assign omax_ext = $signed({{(ACC_W-OUT_W){cfg.out_max[OUT_W-1]}}, cfg.out_max});

  always_comb begin
    if (shifted < omin_ext) begin
      res_cl = cfg.out_min;
    end else if (shifted > omax_ext) begin
      res_cl = cfg.out_max;
    end else begin
      res_cl = shifted[OUT_W-1:0];
    end
  end

  assign res = b3_en_r ? res_cl : '0;

  // Result buffer: push from the last stage, drain to the output channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (b3_v_r) begin
        owr_r <= owr_r + 1'b1;
      end
      if (out_take) begin
        ord_r <= ord_r + 1'b1;
      end
      ocnt_r <= ocnt_r + {{(OCNT_W-1){1'b0}}, b3_v_r} - {{(OCNT_W-1){1'b0}}, out_take};
    end
  end

  always_ff @(posedge clk) begin
    if (b3_v_r) begin
      obuf_r[owr_r] <= res;
    end
  end

  assign out_valid       = (ocnt_r != '0);
  assign out_control_out = obuf_r[ord_r];

endmodule

// ----- hdl/fixed_point_pid_with_clamps.sv -----
// ----------------------------------------------------------------------------
// fixed_point_pid_with_clamps
// Position-form PID with Q12 gains, error/integral/output clamps and an
// optional integral gate; one control value per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one sample per transaction:
//   setpoint, measurement and an enable flag. Output channel
//   (out_valid/out_stall) returns exactly one control value per sample,
//   in order. Configuration registers are written through cfg_we,
//   cfg_index and cfg_data while no sample is in flight.
//   Throughput: one sample per clock while in_stall is low, set by the
//   integral update in the first back-end stage.
//   A three-stage front end forms the error and increment, an 8-entry
//   queue decouples it from the four-stage back end, which owns the
//   integral state and an 8-entry result buffer.
//   When the receiver stalls, results collect in the buffer, then the
//   queue fills and in_stall rises; nothing is dropped.
//   Reset clears the integral, last error and all pipelines, and loads the
//   registers with their defaults (gains 0, full limits, mode 0).
// ----------------------------------------------------------------------------
module fixed_point_pid_with_clamps (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [fppid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fppid_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [fppid_pkg::SMP_W-1:0]      in_setpoint,
  input  logic signed [fppid_pkg::SMP_W-1:0]      in_measured,
  input  logic                                    in_enable,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [fppid_pkg::OUT_W-1:0]      out_control_out
);
  import fppid_pkg::*;

  cfg_t cfg_r;
  logic q_push;
  logic q_pop;
  logic q_empty;
  fq_t  q_wdata;
  fq_t  q_head;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.error_limit    <= 16'hFFFF;
      cfg_r.integral_limit <= 24'hFFFFFF;
      cfg_r.out_min        <= -16'sd32768;
      cfg_r.out_max        <= 16'sd32767;
      cfg_r.mode           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:         cfg_r.gain_p         <= $signed(cfg_data);
        REG_GAIN_I:         cfg_r.gain_i         <= $signed(cfg_data);
        REG_GAIN_D:         cfg_r.gain_d         <= $signed(cfg_data);
        REG_ERROR_LIMIT:    cfg_r.error_limit    <= cfg_data[15:0];
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_data;
        REG_OUT_MIN:        cfg_r.out_min        <= $signed(cfg_data[OUT_W-1:0]);
        REG_OUT_MAX:        cfg_r.out_max        <= $signed(cfg_data[OUT_W-1:0]);
        REG_MODE:           cfg_r.mode           <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  fppid_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_setpoint (in_setpoint),
    .in_measured (in_measured),
    .in_enable   (in_enable),
    .q_pop       (q_pop),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  fppid_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  fppid_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_control_out (out_control_out)
  );

endmodule

// ----- dv/tb_fixed_point_pid_with_clamps.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_point_pid_with_clamps
// Self-checking bench for the Q12 PID controller with error, integral and
// output clamps. A tracker class mirrors the register file and the integral
// and last-error state, predicts each control value at input acceptance and
// compares the results in order. Stimulus is a short directed set covering
// extremes and corner settings, then randomized settings phases with random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_fixed_point_pid_with_clamps;
  import fppid_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int PRESSURE_PHASE  = 6;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_CYCLES    = 30;

  typedef struct packed {
    logic signed [SMP_W-1:0] setpoint;
    logic signed [SMP_W-1:0] measured;
    logic                    enable;
  } sample_t;

  // Mirror of the register file and loop state; holds expected control values
  class pid_tracker;
    cfg_t                    regs;
    logic signed [SUM_W-1:0] integral;
    logic signed [DE_W-1:0]  prev_err;
    logic signed [OUT_W-1:0] control_q[$];
    int unsigned             n_samples;
    int unsigned             n_checked;
    int unsigned             n_errors;
    int unsigned             n_disabled;
    int unsigned             n_bound_hits;
    int unsigned             n_int_sat;

    function new();
      regs.gain_p         = '0;
      regs.gain_i         = '0;
      regs.gain_d         = '0;
      regs.error_limit    = 16'hFFFF;
      regs.integral_limit = 24'hFFFFFF;
      regs.out_min        = 16'sh8000;
      regs.out_max        = 16'sh7FFF;
      regs.mode           = '0;
      integral            = '0;
      prev_err            = '0;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Apply one register write, masking to each register's width
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P:         regs.gain_p = data;
        REG_GAIN_I:         regs.gain_i = data;
        REG_GAIN_D:         regs.gain_d = data;
        REG_ERROR_LIMIT:    regs.error_limit = data[15:0];
        REG_INTEGRAL_LIMIT: regs.integral_limit = data;
        REG_OUT_MIN:        regs.out_min = data[OUT_W-1:0];
        REG_OUT_MAX:        regs.out_max = data[OUT_W-1:0];
        REG_MODE:           regs.mode = data[2:0];
        default: ;
      endcase
    endfunction

    // Advance the loop state by one sample and return the control value
    function logic signed [OUT_W-1:0] predict_control(logic signed [SMP_W-1:0] sp,
                                                       logic signed [SMP_W-1:0] ms,
                                                       logic en);
      longint e, inc, raw, s, acc, y, lim_e, lim_i;
      if (!en) begin
        integral = '0;
        prev_err = '0;
        n_disabled++;
        return '0;
      end
      e = longint'(sp) - longint'(ms);
      if (regs.mode[MODE_ERR_DIV10]) e = e / 10;
      lim_e = longint'(regs.error_limit);
      e = clip(e, -lim_e, lim_e);
      inc = regs.mode[MODE_INC_DIV10] ? e / 10 : e;
      if (regs.mode[MODE_GATE] && (e >= GATE_POS || e <= GATE_NEG)) inc = 0;
      lim_i = longint'(regs.integral_limit);
      raw = longint'(integral) + inc;
      s = clip(raw, -lim_i, lim_i);
      if (s != raw) n_int_sat++;
      acc = longint'(regs.gain_p) * e + longint'(regs.gain_i) * s +
            longint'(regs.gain_d) * (e - longint'(prev_err));
      // arithmetic shift floors toward minus infinity
      y = acc >>> COEF_FRAC_BITS;
      if (y < longint'(regs.out_min) || y > longint'(regs.out_max)) n_bound_hits++;
      y = clip(y, longint'(regs.out_min), longint'(regs.out_max));
      integral = SUM_W'(s);
      prev_err = DE_W'(e);
      return OUT_W'(y);
    endfunction

    function void note_sample(logic signed [SMP_W-1:0] sp, logic signed [SMP_W-1:0] ms,
                              logic en);
      n_samples++;
      control_q.push_back(predict_control(sp, ms, en));
    endfunction

    function void check_control(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] exp_val;
      if (control_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected control_out transaction, expected none, actual %0d",
                 $time, got);
        return;
      end
      exp_val = control_q.pop_front();
      n_checked++;
      if (got !== exp_val) begin
        n_errors++;
        $display("%0t: control_out mismatch, expected %0d, actual %0d", $time, exp_val, got);
      end
    endfunction

    function int pending();
      return control_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [CFG_DATA_W-1:0]          cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [SMP_W-1:0]        in_setpoint;
  logic signed [SMP_W-1:0]        in_measured;
  logic                           in_enable;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [OUT_W-1:0]        out_control_out;

  pid_tracker tracker;
  int         gap_pct;
  int         stall_pct;
  bit         hold_req;
  int         n_settings;
  longint     cycles;

  fixed_point_pid_with_clamps u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_setpoint     (in_setpoint),
    .in_measured     (in_measured),
    .in_enable       (in_enable),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_control_out (out_control_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, tracker.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: check each accepted transaction, then pick the next stall
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.check_control(out_control_out);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic cfg_t make_cfg(int gp, int gi, int gd, int el, int il, int omin,
                                    int omax, int md);
    cfg_t c;
    c.gain_p         = GAIN_W'(gp);
    c.gain_i         = GAIN_W'(gi);
    c.gain_d         = GAIN_W'(gd);
    c.error_limit    = 16'(el);
    c.integral_limit = 24'(il);
    c.out_min        = OUT_W'(omin);
    c.out_max        = OUT_W'(omax);
    c.mode           = 3'(md);
    return c;
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 24'sh7FFFFF;
      2:       return 24'sh800000;
      3:       return 24'sd4096;
      4, 5:    return GAIN_W'(int'($urandom_range(0, 32768)) - 16384);
      6:       return GAIN_W'(int'($urandom_range(0, 2048)) - 1024);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t                    c;
    logic signed [OUT_W-1:0] a, b, t;
    c.gain_p = pick_gain();
    c.gain_i = pick_gain();
    c.gain_d = pick_gain();
    case ($urandom_range(0, 4))
      0:       c.error_limit = '0;
      1:       c.error_limit = 16'hFFFF;
      2:       c.error_limit = 16'($urandom_range(1, 20));
      3:       c.error_limit = 16'($urandom_range(50, 2000));
      default: c.error_limit = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       c.integral_limit = '0;
      1:       c.integral_limit = 24'hFFFFFF;
      2:       c.integral_limit = 24'($urandom_range(1, 100));
      3:       c.integral_limit = 24'($urandom_range(100, 200000));
      default: c.integral_limit = 24'($urandom);
    endcase
    a = OUT_W'($urandom);
    b = OUT_W'($urandom);
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    case ($urandom_range(0, 4))
      0: begin
        c.out_min = 16'sh8000;
        c.out_max = 16'sh7FFF;
      end
      // crossed bounds
      1: begin
        c.out_min = b;
        c.out_max = a;
      end
      2: begin
        c.out_min = a;
        c.out_max = a;
      end
      default: begin
        c.out_min = a;
        c.out_max = b;
      end
    endcase
    c.mode = 3'($urandom);
    return c;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.enable   = ($urandom_range(0, 19) != 0);
    s.setpoint = SMP_W'($urandom);
    case ($urandom_range(0, 3))
      0: s.measured = SMP_W'($urandom);
      1: s.measured = s.setpoint - SMP_W'(int'($urandom_range(0, 20)) - 10);
      2: s.measured = s.setpoint - SMP_W'(int'($urandom_range(0, 200)) - 100);
      default: begin
        s.setpoint = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        s.measured = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
    endcase
    return s;
  endfunction

  // Write every register; stray upper bits check the masking of narrow ones
  task automatic load_settings(input cfg_t c);
    logic [CFG_DATA_W-1:0] val[8];
    val[REG_GAIN_P]         = c.gain_p;
    val[REG_GAIN_I]         = c.gain_i;
    val[REG_GAIN_D]         = c.gain_d;
    val[REG_ERROR_LIMIT]    = {8'($urandom), c.error_limit};
    val[REG_INTEGRAL_LIMIT] = c.integral_limit;
    val[REG_OUT_MIN]        = {8'($urandom), c.out_min};
    val[REG_OUT_MAX]        = {8'($urandom), c.out_max};
    val[REG_MODE]           = {21'($urandom), c.mode};
    for (int r = 0; r < 8; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= val[r];
      @(posedge clk);
      tracker.set_reg(CFG_IDX_W'(r), val[r]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Offer one sample, hold it until accepted, then maybe idle
  task automatic send_sample(input sample_t s);
    in_valid    <= 1'b1;
    in_setpoint <= s.setpoint;
    in_measured <= s.measured;
    in_enable   <= s.enable;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_sample(s.setpoint, s.measured, s.enable);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic feed(input int sp, input int ms, input bit en);
    sample_t s;
    s.setpoint = SMP_W'(sp);
    s.measured = SMP_W'(ms);
    s.enable   = en;
    send_sample(s);
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    tracker     = new();
    gap_pct     = 20;
    stall_pct   = 20;
    hold_req    = 1'b0;
    n_settings  = 0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    in_setpoint <= '0;
    in_measured <= '0;
    in_enable   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-scale errors, disable, small negative values with fractional gains
    load_settings(make_cfg(4100, 3, -2050, 65535, 24'hFFFFFF, -32768, 32767, 0));
    feed(32767, -32768, 1);
    feed(32767, -32768, 1);
    feed(-32768, 32767, 1);
    feed(0, 0, 0);
    feed(100, -100, 1);
    feed(0, 1, 1);
    feed(5, 5, 1);
    settle();

    // All mode bits, tiny error limit, integral held at zero
    load_settings(make_cfg(1, -1, 4096, 3, 0, -32768, 32767, 7));
    feed(0, 7, 1);
    feed(0, -7, 1);
    feed(0, -59, 1);
    feed(0, 33, 1);
    feed(-32768, 32767, 1);
    settle();

    // Crossed output bounds
    load_settings(make_cfg(4096, 0, 0, 65535, 24'hFFFFFF, 100, -100, 0));
    feed(-500, 0, 1);
    feed(150, 0, 1);
    feed(100, 0, 1);
    feed(0, 0, 0);
    settle();

    // Zero error limit with extreme gains and the gate on
    load_settings(make_cfg(24'h7FFFFF, 24'h800000, 24'h800000, 0, 24'hFFFFFF, -32768, 32767, 4));
    feed(32767, -32768, 1);
    feed(1, 0, 1);
    feed(0, 0, 1);
    settle();

    // Opposite extreme gains, increment divided by ten
    load_settings(make_cfg(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 65535, 24'hFFFFFF, -32768, 32767,
                           2));
    feed(32767, -32768, 1);
    feed(-32768, 32767, 1);
    feed(-32768, 32767, 0);
    feed(1234, -4321, 1);
    settle();

    // Randomized settings phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_settings(pick_settings());
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        default: gap_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 30;
      endcase
      // Long receiver hold-off while the sender keeps offering
      if (ph == PRESSURE_PHASE) begin
        gap_pct  = 0;
        hold_req = 1'b1;
      end
      // Run the tail with no idling at all
      if (ph == NUM_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_sample(random_sample());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d control values from %0d samples under %0d register settings",
             tracker.n_checked, tracker.n_samples, n_settings);
    $display("Disabled samples %0d, output clamps %0d, integral saturations %0d",
             tracker.n_disabled, tracker.n_bound_hits, tracker.n_int_sat);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
